@@ rtl/ddm_pkg.sv @@
// ----------------------------------------------------------------------------
// Decimal digit multiplier package
// Shared types, constants, the divide-by-ten helper and the microcode ROM of
// the long multiplication sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddm_pkg;

	// Default operand length limit, in decimal digits.
	localparam int DEFAULT_MAX_DIGITS = 16;

	// One decimal digit.
	localparam int DIGIT_W = 4;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// Input transaction: one operand digit.
	typedef struct packed {
		logic               operand_select;
		logic [DIGIT_W-1:0] digit_value;
		logic               end_of_operands;
	} in_item_t;

	// Output transaction: one product digit.
	typedef struct packed {
		logic [DIGIT_W-1:0] product_digit;
		logic               last_digit;
		logic               too_long;
	} out_item_t;

	// Sequencer steps.
	typedef enum logic [3:0] {
		ST_LOAD      = 4'd0,
		ST_CHECK     = 4'd1,
		ST_MAC       = 4'd2,
		ST_CARRY     = 4'd3,
		ST_NEXT_ROW  = 4'd4,
		ST_SCAN_INIT = 4'd5,
		ST_SCAN      = 4'd6,
		ST_EMIT      = 4'd7,
		ST_FINISH    = 4'd8,
		ST_ZERO      = 4'd9
	} step_t;

	// Sequencing mode of a control word.
	typedef enum logic [1:0] {
		SEQ_NEXT   = 2'd0,  // go to the following step
		SEQ_JUMP   = 2'd1,  // go to the target
		SEQ_BRANCH = 2'd2,  // condition ? target : following step
		SEQ_WAIT   = 2'd3   // condition ? target : stay
	} seq_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		C_TRUE      = 3'd0,
		C_IN_END    = 3'd1,
		C_ZERO_OP   = 3'd2,
		C_J_LAST    = 3'd3,
		C_I_LAST    = 3'd4,
		C_SCAN_HIT  = 3'd5,
		C_EMIT_DONE = 3'd6,
		C_OUT_FREE  = 3'd7
	} cond_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_LOAD      = 4'd1,
		ACT_INIT      = 4'd2,
		ACT_MAC       = 4'd3,
		ACT_CARRY     = 4'd4,
		ACT_NEXT_ROW  = 4'd5,
		ACT_SCAN_INIT = 4'd6,
		ACT_SCAN      = 4'd7,
		ACT_EMIT      = 4'd8,
		ACT_ZERO      = 4'd9,
		ACT_FINISH    = 4'd10
	} act_t;

	// One microcode word.
	typedef struct packed {
		seq_t  seq;
		cond_t cond;
		step_t target;
		act_t  act;
	} uword_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_end;
		logic zero_op;
		logic j_last;
		logic i_last;
		logic scan_hit;
		logic emit_done;
		logic out_free;
	} flags_t;

	// Product digit handed from the datapath to the output register.
	typedef struct packed {
		logic               valid;
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               flag;
	} emit_t;

	// Quotient of a value up to 99 by ten, from nine parallel compares.
	function automatic logic [DIGIT_W-1:0] div10(input logic [6:0] v);
		logic [DIGIT_W-1:0] q;
		q = '0;
		for (int t = 1; t <= 9; t++) begin
			if (v >= 7'(10 * t)) begin
				q = q + 4'd1;
			end
		end
		return q;
	endfunction

	// Microcode program of the long multiplication.
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		case (step)
			ST_LOAD:      w = '{SEQ_WAIT,   C_IN_END,    ST_CHECK,     ACT_LOAD};
			ST_CHECK:     w = '{SEQ_BRANCH, C_ZERO_OP,   ST_ZERO,      ACT_INIT};
			ST_MAC:       w = '{SEQ_WAIT,   C_J_LAST,    ST_CARRY,     ACT_MAC};
			ST_CARRY:     w = '{SEQ_BRANCH, C_I_LAST,    ST_SCAN_INIT, ACT_CARRY};
			ST_NEXT_ROW:  w = '{SEQ_JUMP,   C_TRUE,      ST_MAC,       ACT_NEXT_ROW};
			ST_SCAN_INIT: w = '{SEQ_NEXT,   C_TRUE,      ST_SCAN,      ACT_SCAN_INIT};
			ST_SCAN:      w = '{SEQ_WAIT,   C_SCAN_HIT,  ST_EMIT,      ACT_SCAN};
			ST_EMIT:      w = '{SEQ_WAIT,   C_EMIT_DONE, ST_FINISH,    ACT_EMIT};
			ST_FINISH:    w = '{SEQ_JUMP,   C_TRUE,      ST_LOAD,      ACT_FINISH};
			ST_ZERO:      w = '{SEQ_WAIT,   C_OUT_FREE,  ST_FINISH,    ACT_ZERO};
			default:      w = '{SEQ_JUMP,   C_TRUE,      ST_LOAD,      ACT_NONE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ddm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_ram #(
	parameter int Width = 4,
	parameter int Depth = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
	input  wire logic [Width-1:0]                      wdata,
	input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
	output logic      [Width-1:0]                      rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/ddm_sequencer.sv @@
// ----------------------------------------------------------------------------
// Decimal digit multiplier sequencer
// Step counter over the microcode ROM; picks the next step from the jump
// condition and hands the operation field to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_sequencer import ddm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output act_t        act
);

	step_t  step_q;
	step_t  step_d;
	uword_t uword;
	logic   cond_ok;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
		end else begin
			step_q <= step_d;
		end
	end

	// Control word fetch, condition select and next step.
	always_comb begin
		uword = ucode_rom(step_q);
		act   = uword.act;

		case (uword.cond)
			C_TRUE:      cond_ok = 1'b1;
			C_IN_END:    cond_ok = flags.in_end;
			C_ZERO_OP:   cond_ok = flags.zero_op;
			C_J_LAST:    cond_ok = flags.j_last;
			C_I_LAST:    cond_ok = flags.i_last;
			C_SCAN_HIT:  cond_ok = flags.scan_hit;
			C_EMIT_DONE: cond_ok = flags.emit_done;
			C_OUT_FREE:  cond_ok = flags.out_free;
			default:     cond_ok = 1'b0;
		endcase

		case (uword.seq)
			SEQ_NEXT:   step_d = step_t'(step_q + 4'd1);
			SEQ_JUMP:   step_d = uword.target;
			SEQ_BRANCH: step_d = cond_ok ? uword.target : step_t'(step_q + 4'd1);
			SEQ_WAIT:   step_d = cond_ok ? uword.target : step_q;
			default:    step_d = ST_LOAD;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/ddm_datapath.sv @@
// ----------------------------------------------------------------------------
// Decimal digit multiplier datapath
// Operand digit stores, product digit store, row and column counters, the
// digit multiply-accumulate unit and the product scan counter.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_datapath import ddm_pkg::*; #(
	parameter int MaxDigits = DEFAULT_MAX_DIGITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire act_t     act,
	input  wire logic     in_valid,
	input  wire in_item_t in_data,
	input  wire logic     out_free,
	output logic          in_ready,
	output flags_t        flags,
	output emit_t         emit
);

	localparam int LW = $clog2(MaxDigits + 1);
	localparam int IW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
	localparam int PD = 2 * MaxDigits;
	localparam int PW = $clog2(PD);
	localparam logic [LW-1:0] MAX_LEN = LW'(MaxDigits);

	logic [LW-1:0]      len1_q, len2_q;
	logic               ovf_q;
	logic [IW-1:0]      i_q, i_d;
	logic [IW-1:0]      j_q, j_d;
	logic [PW-1:0]      k_q, k_d;
	logic [DIGIT_W-1:0] carry_q, carry_d;

	logic               accept;
	logic [DIGIT_W-1:0] digit_sat;
	logic               we1, we2;
	logic [IW-1:0]      raddr1, raddr2;
	logic [DIGIT_W-1:0] rdata1, rdata2;
	logic               prod_we;
	logic [PW-1:0]      prod_waddr, prod_raddr;
	logic [DIGIT_W-1:0] prod_wdata, prod_rdata;
	logic [DIGIT_W-1:0] acc_digit;
	logic [6:0]         mac_sum;
	logic [DIGIT_W-1:0] mac_quo;
	logic [DIGIT_W-1:0] mac_rem;
	logic               scan_phase;

	// Input handshake and digit loading.
	assign in_ready  = (act == ACT_LOAD);
	assign accept    = in_valid && in_ready;
	assign digit_sat = (in_data.digit_value > DIGIT_MAX) ? DIGIT_MAX : in_data.digit_value;
	assign we1 = accept && !in_data.operand_select && (len1_q != MAX_LEN);
	assign we2 = accept && in_data.operand_select && (len2_q != MAX_LEN);

	// Operand digit stores, addressed from the least significant digit.
	assign raddr1 = IW'(len1_q - LW'(1) - LW'(i_d));
	assign raddr2 = IW'(len2_q - LW'(1) - LW'(j_d));

	ddm_ram #(.Width(DIGIT_W), .Depth(MaxDigits)) u_first_ram (
		.clk   (clk),
		.we    (we1),
		.waddr (IW'(len1_q)),
		.wdata (digit_sat),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	ddm_ram #(.Width(DIGIT_W), .Depth(MaxDigits)) u_second_ram (
		.clk   (clk),
		.we    (we2),
		.waddr (IW'(len2_q)),
		.wdata (digit_sat),
		.raddr (raddr2),
		.rdata (rdata2)
	);

	// Multiply-accumulate of one digit pair. The first row starts on fresh
	// cells, so the stored value is ignored there.
	assign acc_digit = (i_q == '0) ? '0 : prod_rdata;
	assign mac_sum   = 7'(acc_digit) + 7'(rdata1) * 7'(rdata2) + 7'(carry_q);
	assign mac_quo   = div10(mac_sum);
	assign mac_rem   = DIGIT_W'(mac_sum - 7'({mac_quo, 3'b000}) - 7'({mac_quo, 1'b0}));

	// Product store: digits during the rows, carry at the end of each row.
	assign scan_phase = (act == ACT_SCAN_INIT) || (act == ACT_SCAN) || (act == ACT_EMIT);
	assign prod_we    = (act == ACT_MAC) || (act == ACT_CARRY);
	assign prod_waddr = (act == ACT_CARRY) ? PW'(i_q) + PW'(len2_q) : PW'(i_q) + PW'(j_q);
	assign prod_wdata = (act == ACT_CARRY) ? carry_q : mac_rem;
	assign prod_raddr = scan_phase ? k_d : PW'(i_d) + PW'(j_d);

	ddm_ram #(.Width(DIGIT_W), .Depth(PD)) u_prod_ram (
		.clk   (clk),
		.we    (prod_we),
		.waddr (prod_waddr),
		.wdata (prod_wdata),
		.raddr (prod_raddr),
		.rdata (prod_rdata)
	);

	// Status toward the sequencer.
	always_comb begin
		flags.in_end    = accept && in_data.end_of_operands;
		flags.zero_op   = (len1_q == '0) || (len2_q == '0);
		flags.j_last    = (LW'(j_q) == len2_q - LW'(1));
		flags.i_last    = (LW'(i_q) == len1_q - LW'(1));
		flags.scan_hit  = (prod_rdata != '0) || (k_q == '0);
		flags.emit_done = out_free && (k_q == '0);
		flags.out_free  = out_free;
	end

	// Counter updates for the current operation.
	always_comb begin
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		carry_d = carry_q;
		case (act)
			ACT_INIT: begin
				i_d     = '0;
				j_d     = '0;
				carry_d = '0;
			end
			ACT_MAC: begin
				carry_d = mac_quo;
				j_d     = flags.j_last ? j_q : j_q + IW'(1);
			end
			ACT_NEXT_ROW: begin
				i_d     = i_q + IW'(1);
				j_d     = '0;
				carry_d = '0;
			end
			ACT_SCAN_INIT: begin
				k_d = PW'(PW'(len1_q) + PW'(len2_q) - PW'(1));
			end
			ACT_SCAN: begin
				if (!flags.scan_hit) begin
					k_d = k_q - PW'(1);
				end
			end
			ACT_EMIT: begin
				if (out_free && (k_q != '0)) begin
					k_d = k_q - PW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Product digit toward the output register.
	always_comb begin
		emit.valid = 1'b0;
		emit.digit = prod_rdata;
		emit.last  = (k_q == '0);
		emit.flag  = ovf_q;
		case (act)
			ACT_EMIT: begin
				emit.valid = out_free;
			end
			ACT_ZERO: begin
				emit.valid = out_free;
				emit.digit = '0;
				emit.last  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Loop counters and carry.
	always_ff @(posedge clk) begin
		i_q     <= i_d;
		j_q     <= j_d;
		k_q     <= k_d;
		carry_q <= carry_d;
	end

	// Operand lengths and the dropped digit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len1_q <= '0;
			len2_q <= '0;
			ovf_q  <= 1'b0;
		end else if (act == ACT_FINISH) begin
			len1_q <= '0;
			len2_q <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			if (we1) begin
				len1_q <= len1_q + LW'(1);
			end else if (we2) begin
				len2_q <= len2_q + LW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// A stored product cell is always a single decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		prod_we |-> (prod_wdata <= DIGIT_MAX))
		else $error("product cell written above nine");

	// The row carry stays a single decimal digit.
	a_carry_range: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_MAC) |-> (carry_q <= DIGIT_MAX))
		else $error("row carry above nine");

	// Operand lengths never pass the limit.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len1_q <= MAX_LEN) && (len2_q <= MAX_LEN))
		else $error("operand length above limit");

	// No digit is loaded while a product digit is handed out.
	a_load_vs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !emit.valid)
		else $error("load and emit overlap");

	// After the least significant digit the operands are released.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.last) |=> ##1 ((len1_q == '0) && (len2_q == '0) && !ovf_q))
		else $error("operands not released after product");

endmodule

`default_nettype wire

@@ rtl/decimal_digit_multiplier.sv @@
// ----------------------------------------------------------------------------
// Decimal digit multiplier
// Schoolbook long multiplication of two decimal operands loaded one digit per
// transaction; the product leaves one digit per transaction.
//
//   Channel | Handshake            | Payload    | Moves
//   --------+----------------------+------------+------------------------------
//   in      | in_valid / in_ready  | in_item_t  | one operand digit, MSD first
//   out     | out_valid / out_ready| out_item_t | one product digit, MSD first
//
// A digit without the end mark is taken in the load step. An end digit then
// runs a check step, the row steps (multiply-accumulate, carry, next row), a
// scan start step, a scan over the leading zero cells, the emit step for the
// product digits and a closing step; an empty operand skips rows and scan and
// gives a single 0 before the close. A low out_ready stretches each product
// digit, and in_ready stays low from the end digit through the closing step.
// Reset clears lengths, flags, the step counter and the output valid; the
// stores need no clearing pass.
`default_nettype none

module decimal_digit_multiplier import ddm_pkg::*; #(
	parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	act_t      act;
	flags_t    flags;
	emit_t     emit;
	logic      out_free;
	logic      out_valid_q;
	out_item_t out_data_q;

	ddm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act)
	);

	ddm_datapath #(.MaxDigits(MAX_DIGITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.act      (act),
		.in_valid (in_valid),
		.in_data  (in_data),
		.out_free (out_free),
		.in_ready (in_ready),
		.flags    (flags),
		.emit     (emit)
	);

	// Output register: free when empty or when its transaction completes.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_data_q.product_digit <= emit.digit;
			out_data_q.last_digit    <= emit.last;
			out_data_q.too_long      <= emit.flag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
